[hw/rtl/frlh_pkg.sv]
// ----------------------------------------------------------------------------
// frlh_pkg
// Shared op codes and the command/status bundles between the controller and
// the datapath of the float run-length histogram.
// ----------------------------------------------------------------------------
package frlh_pkg;

    localparam logic [1:0] OP_FEED  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the accepted item
        logic clr_stats;  // zero open run and running statistics
        logic lookup;     // run update, histogram read issue
        logic update;     // histogram write-back, statistics update
        logic sweep;      // zero one histogram entry
        logic out_load;   // load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sweep_last; // sweep is at the last entry
    } t_sts;

endpackage

[hw/rtl/frlh_ctrl.sv]
// ----------------------------------------------------------------------------
// frlh_ctrl
// Sequencer: accepts one item, steps it through lookup and update, runs the
// histogram clearing sweep, and owns the output valid flag.
// ----------------------------------------------------------------------------
module frlh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_op,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  frlh_pkg::t_sts  i_sts,
    output frlh_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_UPDATE = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_op, n_clr_op;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_clr_op    = r_clr_op;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    if (i_op == frlh_pkg::OP_CLEAR) begin
                        o_cmd.clr_stats = 1'b1;
                        n_clr_op        = 1'b1;
                        n_state         = S_SWEEP;
                    end else begin
                        n_state = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_clr_op = 1'b0;
                    n_state  = r_clr_op ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                // hold the finished result until the output slot frees up
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_clr_op    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_op    <= n_clr_op;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hw/rtl/frlh_dpath.sv]
// ----------------------------------------------------------------------------
// frlh_dpath
// Item registers, open-run tracking, histogram memory with read-modify-write,
// saturating statistics, clearing sweep counter and output register.
// ----------------------------------------------------------------------------
module frlh_dpath #(
    parameter int MAX_LINE = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frlh_pkg::t_cmd     i_cmd,
    output frlh_pkg::t_sts     o_sts,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_float_polarity,
    input  logic [1:0]         i_op,
    input  logic signed [7:0]  i_cell_value,
    input  logic               i_end_of_line,
    input  logic [10:0]        i_bin_index,
    output logic [31:0]        o_bin_count,
    output logic [10:0]        o_longest_run,
    output logic [31:0]        o_run_count,
    output logic [31:0]        o_length_total
);

    localparam int LW = $clog2(MAX_LINE + 1);
    localparam logic [LW-1:0] LAST = LW'(MAX_LINE);

    logic [31:0]       r_mem [0:MAX_LINE];

    logic              r_polarity;
    logic [1:0]        r_op;
    logic signed [7:0] r_cell;
    logic              r_eol;
    logic [LW-1:0]     r_idx;
    logic              r_in_range;

    logic [LW-1:0]     r_cur;
    logic [LW-1:0]     r_rec_len;
    logic              r_rec_en;
    logic [31:0]       r_rd_data;
    logic [31:0]       r_bin;
    logic [LW-1:0]     r_longest;
    logic [31:0]       r_runs;
    logic [31:0]       r_sum;
    logic [LW-1:0]     r_sweep_addr;

    logic              w_rising;
    logic              w_float;
    logic              w_feed;
    logic [LW-1:0]     w_run_inc;
    logic [LW-1:0]     w_rec_len;
    logic              w_rec_en;
    logic [LW-1:0]     w_run_nxt;
    logic [LW-1:0]     w_rd_addr;
    logic [31:0]       w_bin_inc;
    logic [31:0]       w_runs_inc;
    logic [32:0]       w_sum_raw;
    logic [31:0]       w_sum_sat;
    logic [31:0]       w_idx_ext;
    logic [31:0]       w_longest_ext;

    assign w_idx_ext = 32'(i_bin_index);

    // run tracking on the captured cell
    assign w_rising  = (r_cell > 8'sd0);
    assign w_float   = r_polarity ? w_rising : !w_rising;
    assign w_feed    = (r_op == frlh_pkg::OP_FEED);
    assign w_run_inc = (r_cur == LAST) ? r_cur : r_cur + LW'(1);
    assign w_rec_len = w_float ? w_run_inc : r_cur;
    assign w_rec_en  = w_feed && (!w_float || r_eol) && (w_rec_len != '0);
    assign w_run_nxt = (w_float && !r_eol) ? w_run_inc : '0;
    assign w_rd_addr = (r_op == frlh_pkg::OP_READ) ? r_idx : w_rec_len;

    // saturating increments
    assign w_bin_inc  = (r_rd_data == '1) ? r_rd_data : r_rd_data + 32'd1;
    assign w_runs_inc = (r_runs == '1) ? r_runs : r_runs + 32'd1;
    assign w_sum_raw  = {1'b0, r_sum} + 33'(r_rec_len);
    assign w_sum_sat  = w_sum_raw[32] ? '1 : w_sum_raw[31:0];

    assign o_sts.sweep_last = (r_sweep_addr == LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity <= 1'b0;
        end else if (i_cfg_valid) begin
            r_polarity <= i_cfg_float_polarity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_cell     <= i_cell_value;
            r_eol      <= i_end_of_line;
            r_idx      <= w_idx_ext[LW-1:0];
            r_in_range <= (w_idx_ext <= 32'(MAX_LINE));
        end
        if (i_cmd.lookup) begin
            r_rec_len <= w_rec_len;
            r_rec_en  <= w_rec_en;
        end
        if (i_cmd.load) begin
            r_bin <= '0;
        end else if (i_cmd.update && (r_op == frlh_pkg::OP_READ) && r_in_range) begin
            r_bin <= r_rd_data;
        end
    end

    // histogram store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_mem[r_sweep_addr] <= '0;
        end else if (i_cmd.update && r_rec_en) begin
            r_mem[r_rec_len] <= w_bin_inc;
        end
        if (i_cmd.lookup) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep_addr <= (r_sweep_addr == LAST) ? '0 : r_sweep_addr + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_stats) begin
            r_cur     <= '0;
            r_longest <= '0;
            r_runs    <= '0;
            r_sum     <= '0;
        end else begin
            if (i_cmd.lookup && w_feed) begin
                r_cur <= w_run_nxt;
            end
            if (i_cmd.update && r_rec_en) begin
                r_runs <= w_runs_inc;
                r_sum  <= w_sum_sat;
                if (r_rec_len > r_longest) begin
                    r_longest <= r_rec_len;
                end
            end
        end
    end

    assign w_longest_ext = 32'(r_longest);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_bin_count    <= r_bin;
            o_longest_run  <= w_longest_ext[10:0];
            o_run_count    <= r_runs;
            o_length_total <= r_sum;
        end
    end

endmodule

[hw/rtl/float_run_length_histogram.sv]
// ----------------------------------------------------------------------------
// float_run_length_histogram
// Measures runs of float cells in a stream of weave grid cells and keeps a
// run-length histogram, longest run, run count and summed length.
// ----------------------------------------------------------------------------
//
//  channel   | valid       | ready       | payload
//  ----------+-------------+-------------+-------------------------------------
//  item in   | i_valid     | o_ready     | i_op, i_cell_value, i_end_of_line,
//            |             |             | i_bin_index
//  result    | o_valid     | i_ready     | o_bin_count, o_longest_run,
//            |             |             | o_run_count, o_length_total
//  config    | i_cfg_valid | o_cfg_ready | i_cfg_float_polarity
//
//  Feed, read and unused ops pass from transfer to result through capture,
//  histogram read, write-back and output load; one item is in flight at a
//  time. A clear op runs the one-entry-per-cycle sweep of the histogram
//  memory before its output load. After reset the same sweep runs with
//  o_ready low. A result held on a stalled output does not block the next
//  transfer in; config writes are always taken.
//
module float_run_length_histogram #(
    parameter int MAX_LINE = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_op,
    input  logic signed [7:0] i_cell_value,
    input  logic              i_end_of_line,
    input  logic [10:0]       i_bin_index,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_bin_count,
    output logic [10:0]       o_longest_run,
    output logic [31:0]       o_run_count,
    output logic [31:0]       o_length_total,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_float_polarity
);

    frlh_pkg::t_cmd s_cmd;
    frlh_pkg::t_sts s_sts;

    assign o_cfg_ready = 1'b1;

    frlh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    frlh_dpath #(
        .MAX_LINE (MAX_LINE)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (s_cmd),
        .o_sts                (s_sts),
        .i_cfg_valid          (i_cfg_valid && o_cfg_ready),
        .i_cfg_float_polarity (i_cfg_float_polarity),
        .i_op                 (i_op),
        .i_cell_value         (i_cell_value),
        .i_end_of_line        (i_end_of_line),
        .i_bin_index          (i_bin_index),
        .o_bin_count          (o_bin_count),
        .o_longest_run        (o_longest_run),
        .o_run_count          (o_run_count),
        .o_length_total       (o_length_total)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item taken while one is in flight");

    a_no_ready_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.sweep |-> !o_ready)
        else $error("input ready during histogram sweep");

    a_sweep_vs_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_cmd.sweep && (s_cmd.update || s_cmd.lookup)))
        else $error("histogram sweep overlaps an item access");

    a_load_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |=> o_valid)
        else $error("output load without valid result");
`endif

endmodule

[verif/float_run_length_histogram_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// float_run_length_histogram_tb
// Self-checking bench for the float run-length histogram. Weave cells, bin
// reads, clears and unused ops go in through a queued driver with random
// gaps. A monitor with random stalls checks every result field against an
// in-bench model of the run tracker and histogram. The polarity register is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module float_run_length_histogram_tb;

    localparam int         MAX_LINE  = 1024;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         GAP_MAX   = 17;
    localparam int         HOLD_OFF  = 400;
    localparam int         WATCHDOG  = 10000;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  cell_val;
        logic        eol;
        logic [10:0] bin_idx;
    } t_cell_item;

    typedef struct packed {
        logic [31:0] bin;
        logic [10:0] longest;
        logic [31:0] runs;
        logic [31:0] total;
    } t_stats;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = frlh_pkg::OP_FEED;
    logic [7:0]  i_cell_value = '0;
    logic        i_end_of_line = 1'b0;
    logic [10:0] i_bin_index = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_bin_count;
    logic [10:0] o_longest_run;
    logic [31:0] o_run_count;
    logic [31:0] o_length_total;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_float_polarity = 1'b0;

    float_run_length_histogram #(
        .MAX_LINE(MAX_LINE)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_op                (i_op),
        .i_cell_value        (i_cell_value),
        .i_end_of_line       (i_end_of_line),
        .i_bin_index         (i_bin_index),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_bin_count         (o_bin_count),
        .o_longest_run       (o_longest_run),
        .o_run_count         (o_run_count),
        .o_length_total      (o_length_total),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_float_polarity(i_cfg_float_polarity)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    logic        polarity_cfg = 1'b0;
    logic [10:0] open_run;
    logic [31:0] run_bins [0:MAX_LINE];
    logic [10:0] longest_seen;
    logic [31:0] runs_seen;
    logic [31:0] lengths_summed;

    t_cell_item pending_cells_q [$];
    t_stats     expected_stats_q [$];
    t_cell_item cur_item;

    int mismatches;
    int results_seen;
    int tx_gap, tx_mode_left, rx_wait, rx_mode_left, quiet_cycles;
    bit tx_burst, rx_burst;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t: %s", $time, msg);
    endtask

    function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void wipe_stats();
        open_run = '0;
        longest_seen = '0;
        runs_seen = '0;
        lengths_summed = '0;
        for (int i = 0; i <= MAX_LINE; i++)
            run_bins[i] = '0;
    endfunction

    function automatic void close_run();
        if (open_run != 0) begin
            run_bins[open_run] = sat_inc(run_bins[open_run], 32'd1);
            runs_seen = sat_inc(runs_seen, 32'd1);
            lengths_summed = sat_inc(lengths_summed, 32'(open_run));
            if (open_run > longest_seen)
                longest_seen = open_run;
        end
        open_run = '0;
    endfunction

    function automatic t_stats histogram_step(input t_cell_item it);
        t_stats r;
        logic   rising;
        logic   floats;
        r.bin = '0;
        case (it.op)
            frlh_pkg::OP_FEED: begin
                rising = !it.cell_val[7] && (it.cell_val != 8'd0);
                floats = polarity_cfg ? rising : !rising;
                if (floats) begin
                    if (open_run < MAX_LINE)
                        open_run++;
                    if (it.eol)
                        close_run();
                end else begin
                    close_run();
                end
            end
            frlh_pkg::OP_READ: begin
                if (it.bin_idx <= MAX_LINE)
                    r.bin = run_bins[it.bin_idx];
            end
            frlh_pkg::OP_CLEAR: wipe_stats();
            default: ;
        endcase
        r.longest = longest_seen;
        r.runs = runs_seen;
        r.total = lengths_summed;
        return r;
    endfunction

    // driver: one item per transfer, random gap after each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                expected_stats_q.push_back(histogram_step(cur_item));
            if (i_valid && !o_ready) begin
                // hold the offered item
            end else if (tx_gap != 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (pending_cells_q.size() != 0) begin
                cur_item = pending_cells_q.pop_front();
                i_op <= cur_item.op;
                i_cell_value <= cur_item.cell_val;
                i_end_of_line <= cur_item.eol;
                i_bin_index <= cur_item.bin_idx;
                i_valid <= 1'b1;
                if (tx_mode_left == 0) begin
                    tx_mode_left = $urandom_range(16, 96);
                    tx_burst = ($urandom_range(0, 2) == 0);
                end
                tx_mode_left--;
                tx_gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result, then stall a random number of cycles
    always @(posedge i_clk) begin
        t_stats exp_stats;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_stats_q.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    exp_stats = expected_stats_q.pop_front();
                    if (o_bin_count !== exp_stats.bin)
                        report_mismatch($sformatf("bin_count got %0d expected %0d",
                                                  o_bin_count, exp_stats.bin));
                    if (o_longest_run !== exp_stats.longest)
                        report_mismatch($sformatf("longest_run got %0d expected %0d",
                                                  o_longest_run, exp_stats.longest));
                    if (o_run_count !== exp_stats.runs)
                        report_mismatch($sformatf("run_count got %0d expected %0d",
                                                  o_run_count, exp_stats.runs));
                    if (o_length_total !== exp_stats.total)
                        report_mismatch($sformatf("length_total got %0d expected %0d",
                                                  o_length_total, exp_stats.total));
                end
                // long back-pressure so the input side fills and stalls
                if (results_seen == 300 || results_seen == 1100) begin
                    rx_wait = HOLD_OFF;
                end else begin
                    if (rx_mode_left == 0) begin
                        rx_mode_left = $urandom_range(16, 96);
                        rx_burst = ($urandom_range(0, 2) == 0);
                    end
                    rx_mode_left--;
                    rx_wait = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
                end
            end
            if (rx_wait != 0) begin
                rx_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] op, input logic [7:0] cell_val,
                             input logic eol, input logic [10:0] idx);
        t_cell_item it;
        it.op = op;
        it.cell_val = cell_val;
        it.eol = eol;
        it.bin_idx = idx;
        pending_cells_q.push_back(it);
    endtask

    // a float or an opposite cell under the current polarity
    function automatic logic [7:0] pick_cell(input logic floats);
        int v;
        if (polarity_cfg ? floats : !floats)
            return 8'($urandom_range(1, 127));
        v = $urandom_range(128, 256);
        return (v == 256) ? 8'd0 : 8'(v);
    endfunction

    task automatic queue_line(input int len, input bit with_eol, input int float_pct);
        for (int i = 0; i < len; i++)
            push_item(frlh_pkg::OP_FEED, pick_cell($urandom_range(0, 99) < float_pct),
                      with_eol && (i == len - 1), 11'($urandom_range(0, 2047)));
    endtask

    task automatic queue_random_cells(input int count);
        int n;
        int k;
        int len;
        n = 0;
        while (n < count) begin
            k = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
            if (k < 70) begin
                queue_line(len, 1'b1, $urandom_range(20, 95));
                n += len;
            end else if (k < 80) begin
                queue_line(len, 1'b0, $urandom_range(20, 95));
                n += len;
            end else if (k < 92) begin
                push_item(frlh_pkg::OP_READ, 8'($urandom), 1'($urandom),
                          ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                                      : 11'($urandom_range(0, 30)));
                n++;
            end else if (k < 96) begin
                push_item(OP_UNUSED, 8'($urandom), 1'($urandom), 11'($urandom));
                n++;
            end else if (k < 97) begin
                push_item(frlh_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 11'($urandom));
                n++;
            end else begin
                push_item(frlh_pkg::OP_FEED, 8'($urandom), 1'($urandom), 11'($urandom));
                n++;
            end
        end
    endtask

    task automatic set_polarity(input logic pol);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_float_polarity <= pol;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        polarity_cfg = pol;
    endtask

    // sampled away from the rising edge so the driver's queue pops are settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_cells_q.size() != 0 || i_valid || expected_stats_q.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic pol_seq [5];
        pol_seq = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        wipe_stats();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_polarity(1'b0);
        // weft polarity: zero and negatives float
        push_item(frlh_pkg::OP_FEED, 8'h00, 1'b0, 11'd0);
        push_item(frlh_pkg::OP_FEED, 8'h80, 1'b0, 11'h7FF);
        push_item(frlh_pkg::OP_FEED, 8'h7F, 1'b0, 11'd0);    // opposite cell ends run of 2
        push_item(frlh_pkg::OP_FEED, 8'hFF, 1'b1, 11'd0);    // run of 1 ends at line end
        push_item(frlh_pkg::OP_FEED, 8'h01, 1'b1, 11'd0);    // opposite cell at line end
        push_item(frlh_pkg::OP_READ, 8'h00, 1'b0, 11'd0);
        push_item(frlh_pkg::OP_READ, 8'h7F, 1'b1, 11'd1);
        push_item(frlh_pkg::OP_READ, 8'h80, 1'b0, 11'd2);
        push_item(frlh_pkg::OP_READ, 8'h00, 1'b0, 11'd1024);
        push_item(frlh_pkg::OP_READ, 8'h00, 1'b0, 11'd1025);
        push_item(frlh_pkg::OP_READ, 8'hFF, 1'b1, 11'h7FF);
        push_item(OP_UNUSED, 8'hFF, 1'b1, 11'h7FF);
        push_item(frlh_pkg::OP_FEED, 8'h00, 1'b0, 11'd0);    // run left open across clear
        push_item(frlh_pkg::OP_CLEAR, 8'h00, 1'b0, 11'd0);
        push_item(frlh_pkg::OP_READ, 8'h00, 1'b0, 11'd1);
        push_item(frlh_pkg::OP_FEED, 8'hC0, 1'b0, 11'd0);
        push_item(frlh_pkg::OP_FEED, 8'h00, 1'b1, 11'd0);
        push_item(frlh_pkg::OP_READ, 8'h00, 1'b0, 11'd2);
        push_item(frlh_pkg::OP_FEED, 8'h00, 1'b0, 11'd0);    // run crosses missing line end
        push_item(frlh_pkg::OP_FEED, 8'h90, 1'b0, 11'd0);
        wait_idle();

        // warp polarity, run longer than a line can hold saturates the length
        set_polarity(1'b1);
        queue_line(MAX_LINE + 6, 1'b1, 100);
        push_item(frlh_pkg::OP_READ, 8'h00, 1'b0, 11'd1024);
        push_item(frlh_pkg::OP_READ, 8'h00, 1'b0, 11'd1023);
        queue_line(2, 1'b0, 100);
        wait_idle();

        foreach (pol_seq[ph]) begin
            set_polarity(pol_seq[ph]);
            queue_random_cells(47);
            queue_line(3, 1'b0, 100);   // open run carried over the next write
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (expected_stats_q.size() != 0)
            report_mismatch("results still expected at end of run");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/frlh_pkg.sv
hw/rtl/frlh_ctrl.sv
hw/rtl/frlh_dpath.sv
hw/rtl/float_run_length_histogram.sv
verif/float_run_length_histogram_tb.sv
